// ===== src/srtf_pkg.sv =====
`timescale 1ns / 1ps

package srtf_pkg;

	// Job table size and derived widths
	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int NLEAF    = 1 << IDX_W;
	localparam int SRCH_W   = $clog2(IDX_W + 1);

	// Field widths and counter limits
	localparam int ID_W    = 8;
	localparam int BURST_W = 16;
	localparam int ORDER_W = 16;
	localparam int WAIT_W  = 24;
	localparam logic [WAIT_W-1:0]  WAIT_MAX  = {WAIT_W{1'b1}};
	localparam logic [ORDER_W-1:0] ORDER_MAX = {ORDER_W{1'b1}};

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Request opcodes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic               op;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic              ran_valid;
		logic [ID_W-1:0]   ran_id;
		logic              done_res;
		logic [WAIT_W-1:0] wait_total;
		logic [WAIT_W-1:0] turnaround;
	} rsp_t;

	// Classified command kinds
	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REJECT = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ID_W-1:0]    job_id;
		logic [BURST_W-1:0] burst;
	} cmd_t;

	// Candidate in the minimum search tree
	typedef struct packed {
		logic               valid;
		logic [BURST_W-1:0] rem;
		logic [ORDER_W-1:0] order;
		logic [IDX_W-1:0]   idx;
	} node_t;

	// Keep the left candidate unless the right one is strictly better
	function automatic node_t pick_best(input node_t a, input node_t b);
		node_t r;
		r = a;
		if (!a.valid) begin
			r = b;
		end else if (b.valid) begin
			if ((b.rem < a.rem) || ((b.rem == a.rem) && (b.order < a.order))) begin
				r = b;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/srtf_front.sv =====
`timescale 1ns / 1ps

module srtf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  srtf_pkg::req_t req_data,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output srtf_pkg::cmd_t cmd
);

	srtf_pkg::cmd_t cmd_s1;
	logic           vld_s1;
	srtf_pkg::cmd_t cls;

	// Classify the request: tick, add, or add that can never be taken
	always_comb begin
		cls.job_id = req_data.job_id;
		cls.burst  = req_data.burst;
		if (req_data.op == srtf_pkg::OP_TICK) begin
			cls.kind = srtf_pkg::CMD_TICK;
		end else if (req_data.burst == '0) begin
			cls.kind = srtf_pkg::CMD_REJECT;
		end else begin
			cls.kind = srtf_pkg::CMD_ADD;
		end
	end

	assign req_ready = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	// Hold the classified request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// ===== src/srtf_fifo.sv =====
`timescale 1ns / 1ps

module srtf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  srtf_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output srtf_pkg::cmd_t pop_data
);

	srtf_pkg::cmd_t                    mem_q [srtf_pkg::FIFO_DEPTH];
	logic [srtf_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [srtf_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [srtf_pkg::FIFO_CNT_W-1:0]   count_q;
	logic                              push;
	logic                              pop;

	assign push_ready = (count_q != srtf_pkg::FIFO_CNT_W'(srtf_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == srtf_pkg::FIFO_PTR_W'(srtf_pkg::FIFO_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == srtf_pkg::FIFO_PTR_W'(srtf_pkg::FIFO_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/srtf_back.sv =====
`timescale 1ns / 1ps

module srtf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  srtf_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output srtf_pkg::rsp_t rsp_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EXEC
	} state_t;

	state_t                              state_q;
	logic [srtf_pkg::SRCH_W-1:0]         srch_cnt_q;
	srtf_pkg::rsp_t                      rsp_q;
	logic                                rsp_valid_q;

	// Job table
	logic                                slot_valid_q  [srtf_pkg::MAX_JOBS];
	logic [srtf_pkg::ID_W-1:0]           slot_id_q     [srtf_pkg::MAX_JOBS];
	logic [srtf_pkg::BURST_W-1:0]        slot_burst_q  [srtf_pkg::MAX_JOBS];
	logic [srtf_pkg::BURST_W-1:0]        slot_rem_q    [srtf_pkg::MAX_JOBS];
	logic [srtf_pkg::WAIT_W-1:0]         slot_wait_q   [srtf_pkg::MAX_JOBS];
	logic [srtf_pkg::ORDER_W-1:0]        slot_order_q  [srtf_pkg::MAX_JOBS];
	logic [srtf_pkg::ORDER_W-1:0]        arrival_q;

	// Search tree: comb leaves, one register per internal node
	srtf_pkg::node_t                     leaf   [srtf_pkg::NLEAF];
	srtf_pkg::node_t                     tree_q [1:srtf_pkg::NLEAF-1];
	srtf_pkg::node_t                     root;

	logic                                out_free;
	logic                                rsp_load;
	logic                                free_found;
	logic [srtf_pkg::IDX_W-1:0]          free_idx;
	logic                                do_add;
	logic                                do_tick;
	logic [srtf_pkg::IDX_W-1:0]          pick;
	logic                                pick_done;
	logic [srtf_pkg::WAIT_W-1:0]         pick_wait;
	logic [srtf_pkg::WAIT_W:0]           tot;
	srtf_pkg::rsp_t                      add_rsp;
	srtf_pkg::rsp_t                      tick_rsp;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign root      = tree_q[1];

	// Build leaves from the table; padding leaves never win
	for (genvar g = 0; g < srtf_pkg::NLEAF; g++) begin : g_leaf
		if (g < srtf_pkg::MAX_JOBS) begin : g_real
			assign leaf[g] = '{valid: slot_valid_q[g], rem: slot_rem_q[g],
				order: slot_order_q[g], idx: srtf_pkg::IDX_W'(g)};
		end else begin : g_pad
			assign leaf[g] = '0;
		end
	end

	// Reduce one tree level per cycle
	for (genvar n = 1; n < srtf_pkg::NLEAF; n++) begin : g_node
		if (2 * n >= srtf_pkg::NLEAF) begin : g_bottom
			always_ff @(posedge clk) begin
				tree_q[n] <= srtf_pkg::pick_best(leaf[2*n-srtf_pkg::NLEAF],
					leaf[2*n+1-srtf_pkg::NLEAF]);
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				tree_q[n] <= srtf_pkg::pick_best(tree_q[2*n], tree_q[2*n+1]);
			end
		end
	end

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
			if (!free_found && !slot_valid_q[s]) begin
				free_found = 1'b1;
				free_idx   = srtf_pkg::IDX_W'(s);
			end
		end
	end

	// Pop a command in idle; an add or a rejected add also needs the output register
	always_comb begin
		cmd_ready = 1'b0;
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_ready = (cmd.kind == srtf_pkg::CMD_TICK) || out_free;
		end
	end

	assign do_add = (state_q == ST_IDLE) && cmd_valid && out_free &&
		(cmd.kind == srtf_pkg::CMD_ADD) && free_found;

	// Load the result register on an add answer or a finished tick
	assign rsp_load = ((state_q == ST_IDLE) && cmd_valid && cmd_ready &&
		(cmd.kind != srtf_pkg::CMD_TICK)) || ((state_q == ST_EXEC) && out_free);

	// Add result
	always_comb begin
		add_rsp          = '0;
		add_rsp.accepted = do_add;
	end

	// Tick result from the winning candidate
	assign pick      = root.idx;
	assign do_tick   = (state_q == ST_EXEC) && out_free && root.valid;
	assign pick_done = (root.rem == srtf_pkg::BURST_W'(1));
	assign pick_wait = slot_wait_q[pick];
	assign tot       = {1'b0, pick_wait} + (srtf_pkg::WAIT_W + 1)'(slot_burst_q[pick]);

	always_comb begin
		tick_rsp = '0;
		if (root.valid) begin
			tick_rsp.ran_valid = 1'b1;
			tick_rsp.ran_id    = slot_id_q[pick];
			if (pick_done) begin
				tick_rsp.done_res   = 1'b1;
				tick_rsp.wait_total = pick_wait;
				tick_rsp.turnaround = tot[srtf_pkg::WAIT_W] ? srtf_pkg::WAIT_MAX
					: tot[srtf_pkg::WAIT_W-1:0];
			end
		end
	end

	// Sequence commands and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			srch_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						if (cmd.kind == srtf_pkg::CMD_TICK) begin
							srch_cnt_q <= '0;
							state_q    <= ST_SEARCH;
						end else begin
							rsp_q <= add_rsp;
						end
					end
				end
				ST_SEARCH: begin
					srch_cnt_q <= srch_cnt_q + 1'b1;
					if (srch_cnt_q == srtf_pkg::SRCH_W'(srtf_pkg::IDX_W - 1)) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						rsp_q   <= tick_rsp;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Slot occupancy and arrival counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
				slot_valid_q[s] <= 1'b0;
			end
			arrival_q <= '0;
		end else begin
			if (do_add) begin
				slot_valid_q[free_idx] <= 1'b1;
				if (arrival_q != srtf_pkg::ORDER_MAX) begin
					arrival_q <= arrival_q + 1'b1;
				end
			end
			if (do_tick && pick_done) begin
				slot_valid_q[pick] <= 1'b0;
			end
		end
	end

	// Slot payload: fill on add, run and age on tick
	always_ff @(posedge clk) begin
		if (do_add) begin
			slot_id_q[free_idx]    <= cmd.job_id;
			slot_burst_q[free_idx] <= cmd.burst;
			slot_rem_q[free_idx]   <= cmd.burst;
			slot_wait_q[free_idx]  <= '0;
			slot_order_q[free_idx] <= arrival_q;
		end
		if (do_tick) begin
			slot_rem_q[pick] <= root.rem - 1'b1;
			for (int s = 0; s < srtf_pkg::MAX_JOBS; s++) begin
				if (srtf_pkg::IDX_W'(s) != pick && slot_valid_q[s] &&
						slot_wait_q[s] != srtf_pkg::WAIT_MAX) begin
					slot_wait_q[s] <= slot_wait_q[s] + 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/shortest_remaining_time_scheduler.sv =====
`timescale 1ns / 1ps
// Answers: an add request is answered from the result register once the back end pops it;
// a tick answers after the minimum search tree has settled and the execute step has run.
// Throughput: one add per cycle while the result side takes each answer; a tick holds
// the back end in the registered search tree and the execute step until it is answered.
// Reset: arst_n clears all slots, the arrival counter, the queue and the output.

module shortest_remaining_time_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  srtf_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output srtf_pkg::rsp_t rsp_data
);

	logic           fq_valid;
	logic           fq_ready;
	srtf_pkg::cmd_t fq_cmd;
	logic           qb_valid;
	logic           qb_ready;
	srtf_pkg::cmd_t qb_cmd;

	srtf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	srtf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_cmd)
	);

	srtf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// An add result never reports a run, and a tick result never an acceptance
	a_add_tick_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.accepted && rsp_data.ran_valid))
		else $error("result reports both an add and a run");

	// Completion only for a job that ran
	a_done_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.done_res) |-> rsp_data.ran_valid)
		else $error("completion without a run");

	// Turnaround covers the wait
	a_turn_ge_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.done_res) |-> (rsp_data.turnaround >= rsp_data.wait_total))
		else $error("turnaround below wait");

	// Timing figures stay zero unless a job finished
	a_zero_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.done_res) |->
			(rsp_data.wait_total == '0 && rsp_data.turnaround == '0))
		else $error("timing figures without completion");

endmodule

// ===== bench/schedule_checker.sv =====
`timescale 1ns / 1ps

module schedule_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  srtf_pkg::req_t req_data,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  srtf_pkg::rsp_t rsp_data,
	output int             errors,
	output int             pending,
	output int             live_jobs
);
	import srtf_pkg::*;

	// Shadow copy of the job table
	logic               job_live   [MAX_JOBS];
	logic [ID_W-1:0]    job_tag    [MAX_JOBS];
	logic [BURST_W-1:0] job_len    [MAX_JOBS];
	logic [BURST_W-1:0] job_left   [MAX_JOBS];
	logic [WAIT_W-1:0]  job_waited [MAX_JOBS];
	logic [ORDER_W-1:0] job_rank   [MAX_JOBS];
	logic [ORDER_W-1:0] arrival_seq;

	rsp_t due_q[$];
	rsp_t want;
	rsp_t next_due;
	int   busy;
	int   k;

	// Apply one request to the shadow table and build the response it must produce
	task automatic schedule_request(input req_t r, output rsp_t e);
		int          pick;
		int          s;
		logic [WAIT_W:0] sum;
		e    = '0;
		pick = -1;
		if (r.op == OP_ADD) begin
			// Take the lowest free slot; a zero burst is refused outright
			if (r.burst != '0) begin
				for (s = 0; s < MAX_JOBS && pick < 0; s++) begin
					if (!job_live[s]) pick = s;
				end
				if (pick >= 0) begin
					job_live[pick]   = 1'b1;
					job_tag[pick]    = r.job_id;
					job_len[pick]    = r.burst;
					job_left[pick]   = r.burst;
					job_waited[pick] = '0;
					job_rank[pick]   = arrival_seq;
					if (arrival_seq != ORDER_MAX) arrival_seq = arrival_seq + 1'b1;
					e.accepted = 1'b1;
				end
			end
		end else begin
			// Find least remaining time, earliest arrival, then lowest slot
			for (s = 0; s < MAX_JOBS; s++) begin
				if (job_live[s] && (pick < 0 || job_left[s] < job_left[pick] ||
						(job_left[s] == job_left[pick] && job_rank[s] < job_rank[pick])))
					pick = s;
			end
			if (pick >= 0) begin
				// Age every other waiting job, holding at the ceiling
				for (s = 0; s < MAX_JOBS; s++) begin
					if (s != pick && job_live[s] && job_waited[s] != WAIT_MAX)
						job_waited[s] = job_waited[s] + 1'b1;
				end
				e.ran_valid    = 1'b1;
				e.ran_id       = job_tag[pick];
				job_left[pick] = job_left[pick] - 1'b1;
				// Retire the job once it runs out
				if (job_left[pick] == '0) begin
					job_live[pick] = 1'b0;
					sum            = {1'b0, job_waited[pick]} + (WAIT_W + 1)'(job_len[pick]);
					e.done_res     = 1'b1;
					e.wait_total   = job_waited[pick];
					e.turnaround   = sum[WAIT_W] ? WAIT_MAX : sum[WAIT_W-1:0];
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [WAIT_W-1:0] want_v,
			input logic [WAIT_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	// Compare responses against the oldest outstanding request, then log new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < MAX_JOBS; k++) job_live[k] = 1'b0;
			arrival_seq = '0;
			due_q.delete();
			pending   <= 0;
			live_jobs <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_q.size() == 0) begin
					$error("response arrived with no request outstanding");
					errors++;
				end else begin
					want = due_q.pop_front();
					check_field("accepted", WAIT_W'(want.accepted),
						WAIT_W'(rsp_data.accepted));
					check_field("ran_valid", WAIT_W'(want.ran_valid),
						WAIT_W'(rsp_data.ran_valid));
					check_field("ran_id", WAIT_W'(want.ran_id), WAIT_W'(rsp_data.ran_id));
					check_field("done_res", WAIT_W'(want.done_res),
						WAIT_W'(rsp_data.done_res));
					check_field("wait_total", want.wait_total, rsp_data.wait_total);
					check_field("turnaround", want.turnaround, rsp_data.turnaround);
				end
			end
			if (req_valid && req_ready) begin
				schedule_request(req_data, next_due);
				due_q.push_back(next_due);
			end
			busy = 0;
			for (k = 0; k < MAX_JOBS; k++) begin
				if (job_live[k]) busy++;
			end
			pending   <= due_q.size();
			live_jobs <= busy;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import srtf_pkg::*;

	localparam int LIMIT        = 200_000;
	localparam int PHASE_ITEMS  = 370;
	localparam int DRAIN_CYCLES = 16;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	int                 errors;
	int                 pending;
	int                 live_jobs;

	int send_idle = 10;
	int recv_idle = 72;
	int cycles    = 0;
	int phase;
	int n;

	shortest_remaining_time_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	schedule_checker sched_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.errors    (errors),
		.pending   (pending),
		.live_jobs (live_jobs)
	);

	always #2 clk = ~clk;

	// Stall the response side at the current rate
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one request, with random gaps ahead of it, and hold it until taken
	task automatic issue(input req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic send_job(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] len);
		req_t r;
		r.op     = OP_ADD;
		r.job_id = id;
		r.burst  = len;
		issue(r);
	endtask

	// Tick payload is don't-care, so scramble it
	task automatic send_tick();
		req_t r;
		r.op     = OP_TICK;
		r.job_id = 8'($urandom_range(255));
		r.burst  = 16'($urandom);
		issue(r);
	endtask

	// Drop valid and wait until every outstanding response is back
	task automatic settle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// Mostly short bursts, some medium, rare long and zero; back off adds near full
	function automatic req_t rand_request();
		req_t r;
		int   roll;
		roll     = $urandom_range(99);
		r.op     = (roll < ((live_jobs >= 12) ? 25 : 55)) ? OP_ADD : OP_TICK;
		r.job_id = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		roll     = $urandom_range(99);
		if (roll < 3)
			r.burst = '0;
		else if (roll < 4)
			r.burst = 16'($urandom_range(65535, 256));
		else if (roll < 8)
			r.burst = 16'($urandom_range(40, 9));
		else
			r.burst = 16'($urandom_range(8, 1));
		return r;
	endfunction

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle tick on an empty table, then a zero-burst add
		send_tick();
		send_job(8'h5A, 16'h0000);
		// Longest and shortest bursts; the short one retires on the next tick
		send_job(8'hFF, 16'hFFFF);
		send_job(8'h00, 16'h0001);
		send_tick();
		// Same id, same burst: the earlier arrival goes first
		send_job(8'h07, 16'h0003);
		send_job(8'h07, 16'h0003);
		// Fill the table, then overflow it
		for (n = 0; n < 13; n++) send_job(8'h80 + 8'(n), 16'(4 + n));
		send_job(8'hAA, 16'h5555);
		repeat (4) send_tick();
		settle();

		// Sender light / receiver heavy, then swapped, then free-running
		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 10 : (phase == 1) ? 72 : 0;
			recv_idle = (phase == 0) ? 72 : (phase == 1) ? 10 : 0;
			repeat (PHASE_ITEMS) issue(rand_request());
			settle();
		end

		// Equal bursts added together run in arrival order
		send_job(8'h11, 16'h0002);
		send_job(8'h22, 16'h0002);
		send_job(8'h33, 16'h0002);
		repeat (6) send_tick();
		repeat (40) issue(rand_request());
		settle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
